// File: hdl/gradient_noise_3d_macros.svh
// Assertion macros shared by the gradient noise RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef GRADIENT_NOISE_3D_MACROS_SVH
`define GRADIENT_NOISE_3D_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GN3D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GN3D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gn3d_pkg.sv
// Shared widths, constants, permutation table and gradient function
// for the 3D gradient noise pipeline. No dependencies.
package gn3d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int INT_W      = 8;
    localparam int HASH_W     = 8;
    localparam int GRAD_W     = 4;
    localparam int OFS_W      = FRAC_BITS + 1;
    localparam int DOT_W      = OFS_W + 2;
    localparam int MF_W       = FRAC_BITS + 5;
    localparam int INNER_W    = FRAC_BITS + 6;
    localparam int MP_W       = INNER_W + OFS_W;
    localparam int FADE_W     = FRAC_BITS + 2;
    localparam int ACC_W      = FRAC_BITS + 10;
    localparam int PROD_W     = FADE_W + ACC_W + 1;
    localparam int NOISE_W    = 18;
    localparam int STAGES     = 10;
    localparam int AXIS_IN_W  = 72;
    localparam int AXIS_OUT_W = 24;

    typedef logic [HASH_W-1:0]           t_hash;
    typedef logic [FRAC_BITS-1:0]        t_frac;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [FADE_W-1:0]    t_fade;

    // Fade polynomial coefficients, scaled to the fraction point
    localparam logic signed [INNER_W-1:0] FADE_C15 = INNER_W'(15 << FRAC_BITS);
    localparam logic signed [INNER_W-1:0] FADE_C10 = INNER_W'(10 << FRAC_BITS);

    // Output clamp limits in Q2.16
    localparam t_acc SAT_HI = ACC_W'(131071);
    localparam t_acc SAT_LO = ACC_W'(-131072);

    // Hash codes that pair the x offset with u = y
    localparam logic [GRAD_W-1:0] GRAD_ZX_A = 4'd12;
    localparam logic [GRAD_W-1:0] GRAD_ZX_B = 4'd14;

    localparam t_hash PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Dot product of the hashed gradient with the corner offset
    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [GRAD_W-1:0]       h,
        input logic signed [OFS_W-1:0] dx,
        input logic signed [OFS_W-1:0] dy,
        input logic signed [OFS_W-1:0] dz
    );
        logic signed [DOT_W-1:0] gu;
        logic signed [DOT_W-1:0] gv;
        gu = h[3] ? DOT_W'(dy) : DOT_W'(dx);
        if (h[3:2] == 2'b00) begin
            gv = DOT_W'(dy);
        end else if (h == GRAD_ZX_A || h == GRAD_ZX_B) begin
            gv = DOT_W'(dx);
        end else begin
            gv = DOT_W'(dz);
        end
        if (h[0]) begin
            gu = -gu;
        end
        if (h[1]) begin
            gv = -gv;
        end
        return gu + gv;
    endfunction

endpackage

// File: hdl/gradient_noise_3d.sv
// Pipelined 3D gradient noise: one Q8.16 point in, one Q2.16 noise value out.
// Throughput: one point per cycle; each of the ten register stages holds its item on a
// downstream stall and fills any bubble below it.
// Reset: i_rst_n (synchronous, active low) clears all stage valid bits; no table fill.
// Depends on gn3d_pkg and gradient_noise_3d_macros.svh.
`include "gradient_noise_3d_macros.svh"

module gradient_noise_3d
    import gn3d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [23:0] x_coord, [47:24] y_coord, [71:48] z_coord
    input  logic [AXIS_IN_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [17:0] noise_value (signed), [23:18] zero
    output logic [AXIS_OUT_W-1:0] o_m_axis_tdata
);

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] en;

    // ---------------- stage 1: first hash level, fade products ----------------
    logic [COORD_W-1:0]            coord [3];
    logic [INT_W-1:0]              ix_p1;
    logic signed [INNER_W-1:0]     s6 [3];
    logic signed [MP_W-1:0]        mp [3];
    logic [2*FRAC_BITS-1:0]        t2p [3];
    t_hash                         n1_a, n1_b;
    t_hash                         r1_a, r1_b, r1_z;
    t_frac                         r1_f [3];
    t_frac                         r1_t2 [3];
    logic signed [MF_W-1:0]        r1_m [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            coord[j] = i_s_axis_tdata[j*COORD_W +: COORD_W];
            t2p[j]   = (2*FRAC_BITS)'(coord[j][FRAC_BITS-1:0])
                     * (2*FRAC_BITS)'(coord[j][FRAC_BITS-1:0]);
            // 6t - 15 by shift and add
            s6[j]    = INNER_W'({coord[j][FRAC_BITS-1:0], 2'b00})
                     + INNER_W'({coord[j][FRAC_BITS-1:0], 1'b0}) - FADE_C15;
            mp[j]    = MP_W'($signed({1'b0, coord[j][FRAC_BITS-1:0]})) * MP_W'(s6[j]);
        end
        ix_p1 = coord[0][FRAC_BITS +: INT_W] + INT_W'(1);
        n1_a  = PERM[coord[0][FRAC_BITS +: INT_W]] + coord[1][FRAC_BITS +: INT_W];
        n1_b  = PERM[ix_p1] + coord[1][FRAC_BITS +: INT_W];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_a <= n1_a;
            r1_b <= n1_b;
            r1_z <= coord[2][FRAC_BITS +: INT_W];
            for (int j = 0; j < 3; j++) begin
                r1_f[j]  <= coord[j][FRAC_BITS-1:0];
                r1_t2[j] <= t2p[j][2*FRAC_BITS-1:FRAC_BITS];
                r1_m[j]  <= mp[j][MF_W+FRAC_BITS-1:FRAC_BITS];
            end
        end
    end

    // ---------------- stage 2: corner bases, t^3 and inner term ----------------
    t_hash                         a_p1, b_p1;
    t_hash                         n2_base [4];
    logic [2*FRAC_BITS-1:0]        t3p [3];
    t_hash                         r2_base [4];
    t_frac                         r2_f [3];
    t_frac                         r2_t3 [3];
    logic signed [INNER_W-1:0]     r2_inner [3];

    always_comb begin
        a_p1 = r1_a + HASH_W'(1);
        b_p1 = r1_b + HASH_W'(1);
        // order: x0y0, x1y0, x0y1, x1y1
        n2_base[0] = PERM[r1_a] + r1_z;
        n2_base[1] = PERM[r1_b] + r1_z;
        n2_base[2] = PERM[a_p1] + r1_z;
        n2_base[3] = PERM[b_p1] + r1_z;
        for (int j = 0; j < 3; j++) begin
            t3p[j] = (2*FRAC_BITS)'(r1_t2[j]) * (2*FRAC_BITS)'(r1_f[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int c = 0; c < 4; c++) begin
                r2_base[c] <= n2_base[c];
            end
            for (int j = 0; j < 3; j++) begin
                r2_f[j]     <= r1_f[j];
                r2_t3[j]    <= t3p[j][2*FRAC_BITS-1:FRAC_BITS];
                r2_inner[j] <= INNER_W'(r1_m[j]) + FADE_C10;
            end
        end
    end

    // ---------------- stage 3: corner hashes, fade weights ----------------
    t_hash                         addr [8];
    logic signed [MP_W-1:0]        fp [3];
    logic [GRAD_W-1:0]             r3_h [8];
    t_frac                         r3_f [3];
    t_fade                         r3_fade [3];

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            addr[c] = r2_base[c[1:0]] + HASH_W'(c[2]);
        end
        for (int j = 0; j < 3; j++) begin
            fp[j] = MP_W'($signed({1'b0, r2_t3[j]})) * MP_W'(r2_inner[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int c = 0; c < 8; c++) begin
                r3_h[c] <= PERM[addr[c]][GRAD_W-1:0];
            end
            for (int j = 0; j < 3; j++) begin
                r3_f[j]    <= r2_f[j];
                r3_fade[j] <= fp[j][FADE_W+FRAC_BITS-1:FRAC_BITS];
            end
        end
    end

    // ---------------- stage 4: gradient dot products ----------------
    logic signed [OFS_W-1:0]       ofs_lo [3];
    logic signed [OFS_W-1:0]       ofs_hi [3];
    t_acc                          n4_d [8];
    t_acc                          r4_d [8];
    t_fade                         r4_fade [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ofs_lo[j] = $signed({1'b0, r3_f[j]});
            // t - 1 in two's complement
            ofs_hi[j] = $signed({1'b1, r3_f[j]});
        end
        for (int c = 0; c < 8; c++) begin
            n4_d[c] = ACC_W'(grad_dot(r3_h[c],
                                      c[0] ? ofs_hi[0] : ofs_lo[0],
                                      c[1] ? ofs_hi[1] : ofs_lo[1],
                                      c[2] ? ofs_hi[2] : ofs_lo[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int c = 0; c < 8; c++) begin
                r4_d[c] <= n4_d[c];
            end
            for (int j = 0; j < 3; j++) begin
                r4_fade[j] <= r3_fade[j];
            end
        end
    end

    // ---------------- stages 5-6: blend along x ----------------
    logic signed [ACC_W:0]         dx_diff [4];
    t_prod                         n5_p [4];
    t_prod                         r5_p [4];
    t_acc                          r5_a [4];
    t_fade                         r5_fade [3];
    t_acc                          r6_l [4];
    t_fade                         r6_fade [3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dx_diff[k] = (ACC_W+1)'(r4_d[2*k+1]) - (ACC_W+1)'(r4_d[2*k]);
            n5_p[k]    = PROD_W'(r4_fade[0]) * PROD_W'(dx_diff[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 4; k++) begin
                r5_p[k] <= n5_p[k];
                r5_a[k] <= r4_d[2*k];
            end
            for (int j = 0; j < 3; j++) begin
                r5_fade[j] <= r4_fade[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 4; k++) begin
                r6_l[k] <= r5_a[k] + ACC_W'(r5_p[k] >>> FRAC_BITS);
            end
            for (int j = 0; j < 3; j++) begin
                r6_fade[j] <= r5_fade[j];
            end
        end
    end

    // ---------------- stages 7-8: blend along y ----------------
    logic signed [ACC_W:0]         dy_diff [2];
    t_prod                         n7_p [2];
    t_prod                         r7_p [2];
    t_acc                          r7_a [2];
    t_fade                         r7_w;
    t_acc                          r8_l [2];
    t_fade                         r8_w;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            dy_diff[k] = (ACC_W+1)'(r6_l[2*k+1]) - (ACC_W+1)'(r6_l[2*k]);
            n7_p[k]    = PROD_W'(r6_fade[1]) * PROD_W'(dy_diff[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 2; k++) begin
                r7_p[k] <= n7_p[k];
                r7_a[k] <= r6_l[2*k];
            end
            r7_w <= r6_fade[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int k = 0; k < 2; k++) begin
                r8_l[k] <= r7_a[k] + ACC_W'(r7_p[k] >>> FRAC_BITS);
            end
            r8_w <= r7_w;
        end
    end

    // ---------------- stages 9-10: blend along z, clamp ----------------
    logic signed [ACC_W:0]         dz_diff;
    t_prod                         n9_p;
    t_prod                         r9_p;
    t_acc                          r9_a;
    t_acc                          sum_z;
    logic signed [NOISE_W-1:0]     n_noise;
    logic signed [NOISE_W-1:0]     r_noise;

    always_comb begin
        dz_diff = (ACC_W+1)'(r8_l[1]) - (ACC_W+1)'(r8_l[0]);
        n9_p    = PROD_W'(r8_w) * PROD_W'(dz_diff);
        sum_z   = r9_a + ACC_W'(r9_p >>> FRAC_BITS);
        if (sum_z > SAT_HI) begin
            n_noise = NOISE_W'(SAT_HI);
        end else if (sum_z < SAT_LO) begin
            n_noise = NOISE_W'(SAT_LO);
        end else begin
            n_noise = NOISE_W'(sum_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r9_p <= n9_p;
            r9_a <= r8_l[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_noise <= n_noise;
        end
    end

    // ---------------- stage control ----------------
    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[STAGES-1] = !r_valid[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_valid[STAGES-1];
    assign o_m_axis_tdata  = {{(AXIS_OUT_W-NOISE_W){1'b0}}, r_noise};

    // ---------------- assertions ----------------
    logic in_fire;
    logic out_fire;
    logic out_stall;

    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire  = o_m_axis_tvalid && i_m_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `GN3D_ASSERT_NXT(a_accept_fills, in_fire, r_valid[0], "accepted transaction not captured")
    `GN3D_ASSERT_NXT(a_out_hold, out_stall, o_m_axis_tvalid && $stable(r_noise), "result changed")
    `GN3D_ASSERT_NXT(a_no_repeat, out_fire && !r_valid[STAGES-2], !o_m_axis_tvalid, "repeated")
    `GN3D_ASSERT_IMP(a_stall_chain, r_valid[4] && !en[5], !en[4], "stage overwritten")

endmodule
